// File: rtl/ehp_pkg.sv
`default_nettype none

package ehp_pkg;

  // Header geometry
  localparam int unsigned HdrBytes = 52;
  localparam logic [31:0] ElfMagic = 32'h7f45_4c46;
  localparam logic [31:0] EtLoProc = 32'h0000_ff00;
  localparam logic [31:0] EtHiProc = 32'h0000_ffff;
  localparam logic [31:0] EtMaxStd = 32'd4;

  // Field ids
  localparam logic [3:0] FID_CLASS    = 4'd0;
  localparam logic [3:0] FID_DATA     = 4'd1;
  localparam logic [3:0] FID_IDENTVER = 4'd2;
  localparam logic [3:0] FID_TYPE     = 4'd3;
  localparam logic [3:0] FID_VERSION  = 4'd5;
  localparam logic [3:0] FID_SHSTRNDX = 4'd15;

  // Error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_MAGIC    = 3'd1;
  localparam logic [2:0] ERR_CLASS    = 3'd2;
  localparam logic [2:0] ERR_DATA     = 3'd3;
  localparam logic [2:0] ERR_IDENTVER = 3'd4;
  localparam logic [2:0] ERR_TYPE     = 3'd5;
  localparam logic [2:0] ERR_VERSION  = 3'd6;

  // Encodings of the class and data bytes
  localparam logic [31:0] ENC_ONE = 32'd1;
  localparam logic [31:0] ENC_TWO = 32'd2;

  // What a byte position holds
  localparam logic [1:0] KIND_MAGIC = 2'd0;
  localparam logic [1:0] KIND_PAD   = 2'd1;
  localparam logic [1:0] KIND_FIELD = 2'd2;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       header_start;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  field_id;
    logic [31:0] field_value;
    logic [2:0]  error_code;
    logic        last_of_header;
  } out_word_t;

  typedef struct packed {
    logic      valid;
    out_word_t word;
  } ehp_res_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] fid;
    logic [1:0] k;
    logic       last;
  } pos_info_t;

  // Map a byte offset to its field, the byte index within it and end flag
  function automatic pos_info_t pos_info(input logic [5:0] pos);
    pos_info_t  r;
    logic [5:0] rel;
    r   = '0;
    rel = '0;
    if (pos < 6'd4) begin
      r.kind = KIND_MAGIC;
      r.k    = pos[1:0];
      r.last = (pos == 6'd3);
    end else if (pos < 6'd7) begin
      r.kind = KIND_FIELD;
      rel    = pos - 6'd4;
      r.fid  = rel[3:0];
      r.last = 1'b1;
    end else if (pos < 6'd16) begin
      r.kind = KIND_PAD;
    end else if (pos < 6'd20) begin
      r.kind = KIND_FIELD;
      rel    = pos - 6'd16;
      r.fid  = 4'd3 + {3'b000, rel[1]};
      r.k    = {1'b0, rel[0]};
      r.last = rel[0];
    end else if (pos < 6'd40) begin
      r.kind = KIND_FIELD;
      rel    = pos - 6'd20;
      r.fid  = 4'd5 + {1'b0, rel[4:2]};
      r.k    = rel[1:0];
      r.last = &rel[1:0];
    end else begin
      r.kind = KIND_FIELD;
      rel    = pos - 6'd40;
      r.fid  = 4'd10 + {1'b0, rel[3:1]};
      r.k    = {1'b0, rel[0]};
      r.last = rel[0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/ehp_core.sv
`default_nettype none

module ehp_core
  import ehp_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     step_i,
  input  wire in_word_t word_i,
  output ehp_res_t      res_o
);

  logic [5:0]  pos_q, pos_d;
  logic [31:0] acc_q, acc_d;
  logic        le_q, le_d;
  logic        halt_q, halt_d;

  logic [5:0]  pos_e;
  logic [31:0] acc_e;
  logic        le_e;
  logic        halt_e;
  pos_info_t   info;
  logic [31:0] base;
  logic [31:0] acc_new;
  logic [2:0]  err;
  logic [5:0]  pos_inc;

  // Apply the start flag before the byte is decoded
  assign pos_e  = word_i.header_start ? 6'd0  : pos_q;
  assign acc_e  = word_i.header_start ? 32'd0 : acc_q;
  assign le_e   = word_i.header_start ? 1'b0  : le_q;
  assign halt_e = word_i.header_start ? 1'b0  : halt_q;
  assign info   = pos_info(pos_e);
  assign pos_inc = pos_e + 6'd1;

  // Decode one byte
  always_comb begin
    base    = (info.k == 2'd0) ? 32'd0 : acc_e;
    acc_new = {acc_e[23:0], word_i.byte_value};
    err     = ERR_NONE;
    pos_d   = pos_e;
    acc_d   = acc_e;
    le_d    = le_e;
    halt_d  = halt_e;
    res_o   = '0;
    if (!halt_e) begin
      case (info.kind)
        KIND_MAGIC: begin
          acc_d = acc_new;
          if (info.last) begin
            acc_d = 32'd0;
            if (acc_new != ElfMagic) begin
              res_o.valid               = 1'b1;
              res_o.word.field_id       = FID_CLASS;
              res_o.word.field_value    = acc_new;
              res_o.word.error_code     = ERR_MAGIC;
              res_o.word.last_of_header = 1'b1;
              halt_d                    = 1'b1;
            end
          end
        end
        KIND_FIELD: begin
          if (le_e) begin
            acc_new = base | ({24'd0, word_i.byte_value} << {info.k, 3'b000});
          end else begin
            acc_new = {base[23:0], word_i.byte_value};
          end
          acc_d = acc_new;
          if (info.last) begin
            acc_d = 32'd0;
            case (info.fid)
              FID_CLASS: begin
                if (acc_new != ENC_ONE && acc_new != ENC_TWO) err = ERR_CLASS;
              end
              FID_DATA: begin
                if (acc_new != ENC_ONE && acc_new != ENC_TWO) err = ERR_DATA;
                else le_d = (acc_new == ENC_ONE);
              end
              FID_IDENTVER: begin
                if (acc_new == 32'd0) err = ERR_IDENTVER;
              end
              FID_TYPE: begin
                if (acc_new > EtMaxStd && acc_new != EtLoProc && acc_new != EtHiProc) begin
                  err = ERR_TYPE;
                end
              end
              FID_VERSION: begin
                if (acc_new == 32'd0) err = ERR_VERSION;
              end
              default: ;
            endcase
            res_o.valid         = 1'b1;
            res_o.word.field_id = info.fid;
            res_o.word.error_code = err;
            if (err != ERR_NONE) begin
              res_o.word.field_value    = acc_new;
              res_o.word.last_of_header = 1'b1;
              halt_d                    = 1'b1;
            end else begin
              res_o.word.field_value    = (info.fid == FID_CLASS) ?
                                          {acc_new[26:0], 5'b00000} : acc_new;
              res_o.word.last_of_header = (info.fid == FID_SHSTRNDX);
            end
          end
        end
        default: ;
      endcase
      // Advance unless this byte halted the parse
      if (!halt_d) begin
        pos_d = pos_inc;
        if (pos_inc == 6'(HdrBytes)) halt_d = 1'b1;
      end
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 6'd0;
      acc_q  <= 32'd0;
      le_q   <= 1'b0;
      halt_q <= 1'b1;
    end else if (step_i) begin
      pos_q  <= pos_d;
      acc_q  <= acc_d;
      le_q   <= le_d;
      halt_q <= halt_d;
    end
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= 6'(HdrBytes))
    else $error("byte position beyond header");

  a_end_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q == 6'(HdrBytes) |-> halt_q)
    else $error("parser running past end of header");

  a_err_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.valid && res_o.word.error_code != ERR_NONE |=> halt_q)
    else $error("parser not halted after error");

endmodule

`default_nettype wire

// File: rtl/elf32_header_parser.sv
// ELF32 file header parser.
// Input channel: one header byte per word (in_data_i.byte_value) with
// header_start set on the first byte of a header; in_valid_i / in_stall_o.
// Output channel: one word per completed field with its id, value, error
// code and a last flag; out_valid_o / out_stall_i. Magic and padding bytes
// produce no word unless the magic check fails.
// Throughput: one byte per cycle while the output is not stalled, with a
// combinational decode between the input register and the output register.
// A byte accepted into the input register is decoded and its word is loaded
// into the output register, which drives out_valid_o.
// Stall: while out_stall_i holds a word, the decode stage holds its byte
// and in_stall_o rises; the stall reaches the input in the same cycle.
// Reset: both pipeline registers empty; the parser waits, ignoring bytes,
// until a byte with header_start. After an error or after byte 51 it
// waits again for the next start.
`default_nettype none

module elf32_header_parser
  import ehp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_word_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_word_t      out_data_o
);

  logic      in_vld_q;
  in_word_t  in_q;
  logic      out_vld_q;
  out_word_t out_q;
  logic      out_free;
  logic      step;
  logic      in_load;
  ehp_res_t  res;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign step       = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_load    = in_valid_i && !in_stall_o;

  ehp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .word_i (in_q),
    .res_o  (res)
  );

  // Pipeline valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (!in_stall_o) in_vld_q <= in_valid_i;
      if (out_free) out_vld_q <= step && res.valid;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_load) in_q <= in_data_i;
    if (out_free && step && res.valid) out_q <= res.word;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.error_code != ERR_NONE |-> out_data_o.last_of_header)
    else $error("error word without last flag");

  a_class_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.field_id == FID_CLASS &&
    out_data_o.error_code == ERR_NONE |->
    out_data_o.field_value == 32'd32 || out_data_o.field_value == 32'd64)
    else $error("class word not 32 or 64");

endmodule

`default_nettype wire
